// ===== design/kvmt_pkg.sv =====
package kvmt_pkg;

    // default geometry of the table
    localparam int ENTRIES_DEF    = 32;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 64;

    // fixed field widths on the ports
    localparam int KEY_FIELD_W   = 32;
    localparam int VALUE_FIELD_W = 64;

    // commands
    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_UPDATE = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;
    localparam logic [1:0] CMD_NEXT   = 2'd3;

    // update modes
    localparam logic [1:0] UPD_ANY      = 2'd0;
    localparam logic [1:0] UPD_NEW_ONLY = 2'd1;
    localparam logic [1:0] UPD_OLD_ONLY = 2'd2;
    localparam logic [1:0] UPD_RSVD     = 2'd3;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_EXISTS    = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_INVALID   = 3'd4;

    typedef struct packed {
        logic [1:0]               cmd;
        logic [KEY_FIELD_W-1:0]   key;
        logic                     has_key;
        logic [VALUE_FIELD_W-1:0] new_value;
        logic [1:0]               update_mode;
    } t_in_item;

    typedef struct packed {
        logic [2:0]               status;
        logic [VALUE_FIELD_W-1:0] read_value;
        logic [KEY_FIELD_W-1:0]   succ_key;
    } t_out_item;

    // commands from the controller to the datapath
    typedef struct packed {
        logic cfg_wr;
        logic init_wr;
        logic load_item;
        logic rd_en;
        logic wr_back;
        logic load_out;
    } t_dp_cmd;

endpackage

// ===== design/kvmt_ctrl.sv =====
module kvmt_ctrl #(
    parameter int ENTRIES = kvmt_pkg::ENTRIES_DEF,
    parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    output kvmt_pkg::t_dp_cmd o_cmd,
    output logic [IDX_W-1:0]  o_idx
);

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_LAST = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    logic [2:0]       r_state, n_state;
    logic [IDX_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    kvmt_pkg::t_dp_cmd cmd;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;
    assign o_idx       = r_cnt;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        cmd         = '0;
        cmd.cfg_wr  = i_cfg_valid;
        unique case (r_state)
            S_INIT: begin
                cmd.init_wr = 1'b1;
                if (r_cnt == LAST_IDX) begin
                    n_state = S_IDLE;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    cmd.load_item = 1'b1;
                    n_state       = S_SCAN;
                    n_cnt         = '0;
                end
            end
            S_SCAN: begin
                cmd.rd_en = 1'b1;
                if (r_cnt == LAST_IDX) begin
                    n_state = S_LAST;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_LAST: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                // write-back repeats while the output is stalled, same data each time
                cmd.wr_back = 1'b1;
                if (!r_out_valid || i_out_ready) begin
                    cmd.load_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
                n_cnt   = '0;
            end
        endcase
        // a mode write restarts the setup pass
        if (i_cfg_valid) begin
            n_state = S_INIT;
            n_cnt   = '0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result appeared without a finished command");

    a_cfg_restarts_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |=> (r_state == S_INIT) && (r_cnt == '0))
        else $error("mode write did not restart the setup pass");

    a_scan_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) && (r_cnt != LAST_IDX) && !i_cfg_valid
        |=> (r_state == S_SCAN) && (r_cnt == IDX_W'($past(r_cnt) + 1'b1)))
        else $error("scan skipped an entry");

endmodule

// ===== design/kvmt_dp.sv =====
module kvmt_dp #(
    parameter int ENTRIES    = kvmt_pkg::ENTRIES_DEF,
    parameter int KEY_BITS   = kvmt_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = kvmt_pkg::VALUE_BITS_DEF,
    parameter int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kvmt_pkg::t_dp_cmd   i_cmd,
    input  logic [IDX_W-1:0]    i_idx,
    input  logic                i_cfg_data,
    input  kvmt_pkg::t_in_item  i_item,
    output kvmt_pkg::t_out_item o_item
);

    localparam int ENT_W = 1 + KEY_BITS + VALUE_BITS;
    localparam int KF_W  = kvmt_pkg::KEY_FIELD_W;
    localparam int VF_W  = kvmt_pkg::VALUE_FIELD_W;

    // entry layout: {valid, key, value}
    logic [ENT_W-1:0] mem [ENTRIES];
    logic [ENT_W-1:0] r_rd_data;
    logic             r_eval_vld;
    logic [IDX_W-1:0] r_eval_idx;

    logic                  r_mode;
    logic [1:0]            r_cmd;
    logic [KEY_BITS-1:0]   r_key;
    logic                  r_has_key;
    logic [VALUE_BITS-1:0] r_val;
    logic [1:0]            r_umode;

    logic                  r_found;
    logic [IDX_W-1:0]      r_match_idx;
    logic [VALUE_BITS-1:0] r_match_val;
    logic                  r_free_found;
    logic [IDX_W-1:0]      r_free_idx;
    logic                  r_first_found;
    logic [KF_W-1:0]       r_first_key;
    logic                  r_next_found;
    logic [KF_W-1:0]       r_succ_key;

    kvmt_pkg::t_out_item r_out;
    kvmt_pkg::t_out_item res;

    logic [KF_W+KEY_BITS-1:0]    in_key_ext;
    logic [VF_W+VALUE_BITS-1:0]  in_val_ext;
    logic [IDX_W+KEY_BITS-1:0]   idx_key_ext;
    logic [KEY_BITS+KF_W-1:0]    ent_key_ext;
    logic [VALUE_BITS+VF_W-1:0]  match_val_ext;
    logic [ENT_W-1:0]            init_data;
    logic                        ent_valid;
    logic [KEY_BITS-1:0]         ent_key;
    logic [VALUE_BITS-1:0]       ent_val;
    logic                        ent_match;
    logic                        wb_en;
    logic [IDX_W-1:0]            wb_idx;
    logic [ENT_W-1:0]            wb_data;

    // field masking and extension
    assign in_key_ext    = {{KEY_BITS{1'b0}}, i_item.key};
    assign in_val_ext    = {{VALUE_BITS{1'b0}}, i_item.new_value};
    assign idx_key_ext   = {{KEY_BITS{1'b0}}, i_idx};
    assign ent_key_ext   = {{KF_W{1'b0}}, ent_key};
    assign match_val_ext = {{VF_W{1'b0}}, r_match_val};

    // array mode presets key i, hash mode starts empty
    assign init_data = r_mode ? {1'b1, idx_key_ext[KEY_BITS-1:0], {VALUE_BITS{1'b0}}}
                              : '0;

    assign ent_valid = r_rd_data[ENT_W-1];
    assign ent_key   = r_rd_data[VALUE_BITS +: KEY_BITS];
    assign ent_val   = r_rd_data[VALUE_BITS-1:0];
    assign ent_match = ent_valid && (ent_key == r_key);

    // table memory, one write and one read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.init_wr) begin
            mem[i_idx] <= init_data;
        end else if (i_cmd.wr_back && wb_en) begin
            mem[wb_idx] <= wb_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[i_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= 1'b0;
            r_eval_vld <= 1'b0;
        end else begin
            r_eval_vld <= i_cmd.rd_en;
            if (i_cmd.cfg_wr) begin
                r_mode <= i_cfg_data;
            end
        end
    end

    // item capture and scan bookkeeping
    always_ff @(posedge i_clk) begin
        r_eval_idx <= i_idx;
        if (i_cmd.load_item) begin
            r_cmd         <= i_item.cmd;
            r_key         <= in_key_ext[KEY_BITS-1:0];
            r_has_key     <= i_item.has_key;
            r_val         <= in_val_ext[VALUE_BITS-1:0];
            r_umode       <= i_item.update_mode;
            r_found       <= 1'b0;
            r_free_found  <= 1'b0;
            r_first_found <= 1'b0;
            r_next_found  <= 1'b0;
        end else if (r_eval_vld) begin
            if (ent_match && !r_found) begin
                r_found     <= 1'b1;
                r_match_idx <= r_eval_idx;
                r_match_val <= ent_val;
            end
            if (!ent_valid && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_eval_idx;
            end
            if (ent_valid && !r_first_found) begin
                r_first_found <= 1'b1;
                r_first_key   <= ent_key_ext[KF_W-1:0];
            end
            // first valid entry strictly after the matching one
            if (ent_valid && r_found && !r_next_found) begin
                r_next_found <= 1'b1;
                r_succ_key   <= ent_key_ext[KF_W-1:0];
            end
        end
    end

    always_comb begin
        res        = '0;
        res.status = kvmt_pkg::ST_OK;
        wb_en      = 1'b0;
        wb_idx     = r_match_idx;
        wb_data    = '0;
        unique case (r_cmd)
            kvmt_pkg::CMD_LOOKUP: begin
                if (r_found) begin
                    res.read_value = match_val_ext[VF_W-1:0];
                end else begin
                    res.status = kvmt_pkg::ST_NOT_FOUND;
                end
            end
            kvmt_pkg::CMD_UPDATE: begin
                priority if (r_umode == kvmt_pkg::UPD_RSVD) begin
                    res.status = kvmt_pkg::ST_INVALID;
                end else if (!r_found && r_umode == kvmt_pkg::UPD_OLD_ONLY) begin
                    res.status = kvmt_pkg::ST_NOT_FOUND;
                end else if (r_found && r_umode == kvmt_pkg::UPD_NEW_ONLY) begin
                    res.status = kvmt_pkg::ST_EXISTS;
                end else if (r_found) begin
                    wb_en   = 1'b1;
                    wb_data = {1'b1, r_key, r_val};
                end else if (r_free_found) begin
                    wb_en   = 1'b1;
                    wb_idx  = r_free_idx;
                    wb_data = {1'b1, r_key, r_val};
                end else begin
                    res.status = kvmt_pkg::ST_FULL;
                end
            end
            kvmt_pkg::CMD_DELETE: begin
                priority if (r_mode) begin
                    res.status = kvmt_pkg::ST_INVALID;
                end else if (r_found) begin
                    wb_en = 1'b1;
                end else begin
                    res.status = kvmt_pkg::ST_NOT_FOUND;
                end
            end
            kvmt_pkg::CMD_NEXT: begin
                if (r_has_key && r_found) begin
                    if (r_next_found) begin
                        res.succ_key = r_succ_key;
                    end else begin
                        res.status = kvmt_pkg::ST_NOT_FOUND;
                    end
                end else if (r_first_found) begin
                    res.succ_key = r_first_key;
                end else begin
                    res.status = kvmt_pkg::ST_NOT_FOUND;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out <= res;
        end
    end

    assign o_item = r_out;

endmodule

// ===== design/key_value_map_table.sv =====
// channel  | valid        | ready        | payload
// ---------+--------------+--------------+------------------------------
// in       | i_in_valid   | o_in_ready   | i_in_item  (cmd, key, ...)
// out      | o_out_valid  | i_out_ready  | o_out_item (status, value, key)
// cfg      | i_cfg_valid  | o_cfg_ready  | i_cfg_data (table_mode)
//
// an item passes from the idle state that takes it through the scan that reads one
//   table entry per cycle, then a read-latency state and a write-back state, before
//   the next item is accepted
// reset and every mode write run a setup pass that fills the table for the mode;
//   no item is taken during it, mode writes are always taken
// a finished result waits in the output register; the next item is accepted
//   meanwhile and only its write-back stage holds until the output frees up
module key_value_map_table #(
    parameter int ENTRIES    = kvmt_pkg::ENTRIES_DEF,
    parameter int KEY_BITS   = kvmt_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = kvmt_pkg::VALUE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  kvmt_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output kvmt_pkg::t_out_item o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_data
);

    // index width into the table
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    kvmt_pkg::t_dp_cmd dp_cmd;
    logic [IDX_W-1:0]  dp_idx;

    // sequencer: setup pass, scan, write-back, output hand-off
    kvmt_ctrl #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (dp_cmd),
        .o_idx       (dp_idx)
    );

    // table memory, match/free/next trackers, result and output register
    kvmt_dp #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS),
        .IDX_W      (IDX_W)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .i_idx      (dp_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_in_item),
        .o_item     (o_out_item)
    );

endmodule

// ===== tb/key_value_map_table_test.sv =====
module key_value_map_table_test;

    localparam int NUM_SLOTS     = kvmt_pkg::ENTRIES_DEF;
    localparam int KW            = kvmt_pkg::KEY_FIELD_W;
    localparam int VW            = kvmt_pkg::VALUE_FIELD_W;
    localparam int RANDOM_ITEMS  = 1900;
    localparam int RANDOM_PHASES = 8;
    localparam int POOL_SIZE     = 48;
    localparam int MAX_REPORTS   = 10;
    // an item scans the whole table; a mode write adds a setup pass
    localparam int DRAIN_CYCLES  = 2 * NUM_SLOTS + 8;
    // the limit sits far above the slowest legal run, leaving a wide margin
    localparam int CYCLE_LIMIT   = 1000000;

    typedef enum {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_SPARSE,
        RDY_TOGGLE
    } t_ready_style;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    kvmt_pkg::t_in_item  i_in_item   = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    kvmt_pkg::t_out_item o_out_item;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic                i_cfg_data  = 1'b0;

    // shadow copy of the table, kept in step with every accepted item
    bit            shadow_mode;
    bit            shadow_valid [NUM_SLOTS];
    logic [KW-1:0] shadow_key   [NUM_SLOTS];
    logic [VW-1:0] shadow_value [NUM_SLOTS];

    // predicted results, oldest first
    kvmt_pkg::t_out_item expected_results[$];

    logic [KW-1:0] key_pool [POOL_SIZE];

    int items_sent      = 0;
    int results_checked = 0;
    int mismatches      = 0;
    int mode_writes     = 0;
    int cycle_count     = 0;
    int burst_left      = 0;
    int status_tally [5];

    t_ready_style ready_style = RDY_ALWAYS;
    int           style_left  = 0;

    key_value_map_table dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // hard stop in case the block hangs
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, expected_results.size());
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // table predictor
    // ------------------------------------------------------------------

    // reset and every mode write rebuild the whole table
    function automatic void load_table_for_mode(input bit mode);
        shadow_mode = mode;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            shadow_valid[i] = mode;
            shadow_key[i]   = mode ? KW'(i) : '0;
            shadow_value[i] = '0;
        end
    endfunction

    // lowest valid slot holding the key, NUM_SLOTS when absent
    function automatic int find_key_slot(input logic [KW-1:0] key);
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (shadow_valid[i] && shadow_key[i] == key) begin
                return i;
            end
        end
        return NUM_SLOTS;
    endfunction

    // key and value widths equal the port fields here, so no masking is needed
    function automatic kvmt_pkg::t_out_item run_table_cmd(input kvmt_pkg::t_in_item op);
        kvmt_pkg::t_out_item res;
        int                  idx;
        int                  start;
        res = '0;
        res.status = kvmt_pkg::ST_OK;
        case (op.cmd)
            kvmt_pkg::CMD_LOOKUP: begin
                idx = find_key_slot(op.key);
                if (idx < NUM_SLOTS) begin
                    res.read_value = shadow_value[idx];
                end else begin
                    res.status = kvmt_pkg::ST_NOT_FOUND;
                end
            end
            kvmt_pkg::CMD_UPDATE: begin
                idx = find_key_slot(op.key);
                if (op.update_mode == kvmt_pkg::UPD_RSVD) begin
                    res.status = kvmt_pkg::ST_INVALID;
                end else if (idx == NUM_SLOTS &&
                             op.update_mode == kvmt_pkg::UPD_OLD_ONLY) begin
                    res.status = kvmt_pkg::ST_NOT_FOUND;
                end else if (idx < NUM_SLOTS &&
                             op.update_mode == kvmt_pkg::UPD_NEW_ONLY) begin
                    res.status = kvmt_pkg::ST_EXISTS;
                end else begin
                    // new key goes to the lowest free slot
                    if (idx == NUM_SLOTS) begin
                        for (idx = 0; idx < NUM_SLOTS; idx++) begin
                            if (!shadow_valid[idx]) break;
                        end
                    end
                    if (idx == NUM_SLOTS) begin
                        res.status = kvmt_pkg::ST_FULL;
                    end else begin
                        shadow_valid[idx] = 1'b1;
                        shadow_key[idx]   = op.key;
                        shadow_value[idx] = op.new_value;
                    end
                end
            end
            kvmt_pkg::CMD_DELETE: begin
                if (shadow_mode) begin
                    res.status = kvmt_pkg::ST_INVALID;
                end else begin
                    idx = find_key_slot(op.key);
                    if (idx < NUM_SLOTS) begin
                        shadow_valid[idx] = 1'b0;
                        shadow_key[idx]   = '0;
                        shadow_value[idx] = '0;
                    end else begin
                        res.status = kvmt_pkg::ST_NOT_FOUND;
                    end
                end
            end
            kvmt_pkg::CMD_NEXT: begin
                // absent start key falls back to the first slot
                start = 0;
                if (op.has_key) begin
                    idx = find_key_slot(op.key);
                    if (idx < NUM_SLOTS) start = idx + 1;
                end
                res.status = kvmt_pkg::ST_NOT_FOUND;
                for (idx = start; idx < NUM_SLOTS; idx++) begin
                    if (shadow_valid[idx]) begin
                        res.succ_key = shadow_key[idx];
                        res.status   = kvmt_pkg::ST_OK;
                        break;
                    end
                end
            end
        endcase
        status_tally[res.status]++;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // drivers and result checker
    // ------------------------------------------------------------------

    function automatic kvmt_pkg::t_in_item table_op(input logic [1:0] cmd,
                                                    input logic [KW-1:0] key,
                                                    input logic has_key,
                                                    input logic [VW-1:0] value,
                                                    input logic [1:0] umode);
        kvmt_pkg::t_in_item op;
        op.cmd         = cmd;
        op.key         = key;
        op.has_key     = has_key;
        op.new_value   = value;
        op.update_mode = umode;
        return op;
    endfunction

    // sends one item; bursts of random length with random gaps in between,
    // valid stays high from one item to the next inside a burst
    task automatic send_item(input kvmt_pkg::t_in_item op);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_item  <= op;
        do @(posedge i_clk); while (!o_in_ready);
        expected_results.push_back(run_table_cmd(op));
        items_sent++;
    endtask

    // drop valid and hold off until every predicted result has come back
    task automatic wait_table_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_table_mode(input bit mode);
        wait_table_idle();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        load_table_for_mode(mode);
        mode_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // receiver back-pressure: switches between its own stall styles
    always @(negedge i_clk) begin
        if (style_left == 0) begin
            ready_style = t_ready_style'($urandom_range(0, 3));
            style_left  = $urandom_range(20, 200);
        end
        style_left--;
        case (ready_style)
            RDY_ALWAYS: i_out_ready <= 1'b1;
            RDY_COIN:   i_out_ready <= 1'($urandom_range(0, 1));
            RDY_SPARSE: i_out_ready <= ($urandom_range(0, 7) == 0);
            RDY_TOGGLE: i_out_ready <= ~i_out_ready;
        endcase
    end

    always @(posedge i_clk) begin : check_results
        kvmt_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_checked++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected result: status %0d value %h next key %h",
                             o_out_item.status, o_out_item.read_value,
                             o_out_item.succ_key);
                end
            end else begin
                want = expected_results.pop_front();
                if (o_out_item.status !== want.status ||
                    o_out_item.read_value !== want.read_value ||
                    o_out_item.succ_key !== want.succ_key) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("result %0d: expected status %0d value %h next key %h",
                                 results_checked, want.status, want.read_value,
                                 want.succ_key);
                        $display("result %0d:      got status %0d value %h next key %h",
                                 results_checked, o_out_item.status,
                                 o_out_item.read_value, o_out_item.succ_key);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // hash mode from reset: empty table, every update mode, in-place rewrite,
    // walk order, delete and reuse of the lowest free slot
    task automatic test_hash_directed();
        logic [KW-1:0] k_max;
        logic [VW-1:0] v_max;
        k_max = '1;
        v_max = '1;
        send_item(table_op(kvmt_pkg::CMD_LOOKUP, '0, 1'b0, '0, kvmt_pkg::UPD_ANY));
        send_item(table_op(kvmt_pkg::CMD_NEXT, '0, 1'b0, '0, kvmt_pkg::UPD_ANY));
        send_item(table_op(kvmt_pkg::CMD_DELETE, 32'd5, 1'b0, '0, kvmt_pkg::UPD_ANY));
        send_item(table_op(kvmt_pkg::CMD_UPDATE, 32'd7, 1'b0, 64'd1, kvmt_pkg::UPD_RSVD));
        send_item(table_op(kvmt_pkg::CMD_UPDATE, 32'd7, 1'b0, 64'd1,
                           kvmt_pkg::UPD_OLD_ONLY));
        send_item(table_op(kvmt_pkg::CMD_UPDATE, '0, 1'b0, '0, kvmt_pkg::UPD_ANY));
        send_item(table_op(kvmt_pkg::CMD_UPDATE, k_max, 1'b1, v_max,
                           kvmt_pkg::UPD_NEW_ONLY));
        send_item(table_op(kvmt_pkg::CMD_UPDATE, k_max, 1'b1, 64'd3,
                           kvmt_pkg::UPD_NEW_ONLY));
        send_item(table_op(kvmt_pkg::CMD_UPDATE, k_max, 1'b0, 64'h5555_5555_5555_5555,
                           kvmt_pkg::UPD_OLD_ONLY));
        send_item(table_op(kvmt_pkg::CMD_UPDATE, '0, 1'b1, 64'haaaa_aaaa_aaaa_aaaa,
                           kvmt_pkg::UPD_ANY));
        send_item(table_op(kvmt_pkg::CMD_LOOKUP, k_max, 1'b0, '0, kvmt_pkg::UPD_ANY));
        send_item(table_op(kvmt_pkg::CMD_LOOKUP, '0, 1'b1, v_max, kvmt_pkg::UPD_RSVD));
        // key is ignored when has_key is low
        send_item(table_op(kvmt_pkg::CMD_NEXT, k_max, 1'b0, '0, kvmt_pkg::UPD_ANY));
        send_item(table_op(kvmt_pkg::CMD_NEXT, '0, 1'b1, '0, kvmt_pkg::UPD_ANY));
        send_item(table_op(kvmt_pkg::CMD_NEXT, k_max, 1'b1, '0, kvmt_pkg::UPD_ANY));
        send_item(table_op(kvmt_pkg::CMD_NEXT, 32'h0001_2345, 1'b1, '0,
                           kvmt_pkg::UPD_ANY));
        send_item(table_op(kvmt_pkg::CMD_DELETE, '0, 1'b0, '0, kvmt_pkg::UPD_ANY));
        send_item(table_op(kvmt_pkg::CMD_LOOKUP, '0, 1'b0, '0, kvmt_pkg::UPD_ANY));
        send_item(table_op(kvmt_pkg::CMD_NEXT, '0, 1'b0, '0, kvmt_pkg::UPD_ANY));
        // freed slot 0 is taken again ahead of later slots
        send_item(table_op(kvmt_pkg::CMD_UPDATE, 32'h8000_0000, 1'b0, 64'd1,
                           kvmt_pkg::UPD_ANY));
        send_item(table_op(kvmt_pkg::CMD_NEXT, 32'h8000_0000, 1'b1, '0,
                           kvmt_pkg::UPD_ANY));
        send_item(table_op(kvmt_pkg::CMD_DELETE, k_max, 1'b0, '0, kvmt_pkg::UPD_ANY));
        send_item(table_op(kvmt_pkg::CMD_DELETE, k_max, 1'b0, '0, kvmt_pkg::UPD_ANY));
        send_item(table_op(kvmt_pkg::CMD_NEXT, 32'h8000_0000, 1'b1, '0,
                           kvmt_pkg::UPD_ANY));
        wait_table_idle();
    endtask

    // array mode: keys preset to the slot index, always full, delete refused
    task automatic test_array_directed();
        write_table_mode(1'b1);
        send_item(table_op(kvmt_pkg::CMD_LOOKUP, '0, 1'b0, '0, kvmt_pkg::UPD_ANY));
        send_item(table_op(kvmt_pkg::CMD_LOOKUP, NUM_SLOTS - 1, 1'b0, '0,
                           kvmt_pkg::UPD_ANY));
        send_item(table_op(kvmt_pkg::CMD_LOOKUP, NUM_SLOTS, 1'b0, '0, kvmt_pkg::UPD_ANY));
        send_item(table_op(kvmt_pkg::CMD_LOOKUP, '1, 1'b0, '0, kvmt_pkg::UPD_ANY));
        send_item(table_op(kvmt_pkg::CMD_UPDATE, 32'd5, 1'b0, '1, kvmt_pkg::UPD_ANY));
        send_item(table_op(kvmt_pkg::CMD_LOOKUP, 32'd5, 1'b0, '0, kvmt_pkg::UPD_ANY));
        send_item(table_op(kvmt_pkg::CMD_UPDATE, 32'd3, 1'b0, 64'd9,
                           kvmt_pkg::UPD_NEW_ONLY));
        send_item(table_op(kvmt_pkg::CMD_UPDATE, 32'd100, 1'b0, 64'd9, kvmt_pkg::UPD_ANY));
        send_item(table_op(kvmt_pkg::CMD_UPDATE, 32'd100, 1'b0, 64'd9,
                           kvmt_pkg::UPD_NEW_ONLY));
        send_item(table_op(kvmt_pkg::CMD_UPDATE, 32'd100, 1'b0, 64'd9,
                           kvmt_pkg::UPD_OLD_ONLY));
        send_item(table_op(kvmt_pkg::CMD_UPDATE, 32'd2, 1'b0, 64'd9, kvmt_pkg::UPD_RSVD));
        send_item(table_op(kvmt_pkg::CMD_DELETE, 32'd4, 1'b0, '0, kvmt_pkg::UPD_ANY));
        send_item(table_op(kvmt_pkg::CMD_DELETE, 32'd100, 1'b0, '0, kvmt_pkg::UPD_ANY));
        send_item(table_op(kvmt_pkg::CMD_NEXT, 32'd7, 1'b0, '0, kvmt_pkg::UPD_ANY));
        send_item(table_op(kvmt_pkg::CMD_NEXT, 32'd7, 1'b1, '0, kvmt_pkg::UPD_ANY));
        send_item(table_op(kvmt_pkg::CMD_NEXT, NUM_SLOTS - 1, 1'b1, '0,
                           kvmt_pkg::UPD_ANY));
        send_item(table_op(kvmt_pkg::CMD_NEXT, 32'd999, 1'b1, '0, kvmt_pkg::UPD_ANY));
        wait_table_idle();
    endtask

    // fill the hash table, hit the full case, free one slot and refill it
    task automatic test_table_full();
        logic [KW-1:0] filled [NUM_SLOTS];
        logic [KW-1:0] fresh_key;
        write_table_mode(1'b0);
        for (int i = 0; i < NUM_SLOTS; i++) begin
            filled[i] = $urandom;
            send_item(table_op(kvmt_pkg::CMD_UPDATE, filled[i], 1'b0, {$urandom, $urandom},
                               kvmt_pkg::UPD_NEW_ONLY));
        end
        fresh_key = ~filled[0];
        send_item(table_op(kvmt_pkg::CMD_UPDATE, fresh_key, 1'b0, 64'd1,
                           kvmt_pkg::UPD_ANY));
        send_item(table_op(kvmt_pkg::CMD_UPDATE, fresh_key, 1'b0, 64'd1,
                           kvmt_pkg::UPD_NEW_ONLY));
        send_item(table_op(kvmt_pkg::CMD_DELETE, filled[9], 1'b0, '0, kvmt_pkg::UPD_ANY));
        send_item(table_op(kvmt_pkg::CMD_UPDATE, fresh_key, 1'b0, {$urandom, $urandom},
                           kvmt_pkg::UPD_ANY));
        send_item(table_op(kvmt_pkg::CMD_NEXT, filled[8], 1'b1, '0, kvmt_pkg::UPD_ANY));
        send_item(table_op(kvmt_pkg::CMD_LOOKUP, fresh_key, 1'b0, '0, kvmt_pkg::UPD_ANY));
        wait_table_idle();
    endtask

    // random commands over a small key pool so hits, full and churn are common;
    // a few keys are fully random as noise
    function automatic kvmt_pkg::t_in_item random_table_op();
        kvmt_pkg::t_in_item op;
        int                 pick;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            op.cmd = kvmt_pkg::CMD_LOOKUP;
        end else if (pick < 60) begin
            op.cmd = kvmt_pkg::CMD_UPDATE;
        end else if (pick < 80) begin
            op.cmd = kvmt_pkg::CMD_DELETE;
        end else begin
            op.cmd = kvmt_pkg::CMD_NEXT;
        end
        op.key       = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                                    : $urandom;
        op.has_key   = ($urandom_range(0, 99) < 85);
        op.new_value = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            op.update_mode = kvmt_pkg::UPD_ANY;
        end else if (pick < 65) begin
            op.update_mode = kvmt_pkg::UPD_NEW_ONLY;
        end else if (pick < 90) begin
            op.update_mode = kvmt_pkg::UPD_OLD_ONLY;
        end else begin
            op.update_mode = kvmt_pkg::UPD_RSVD;
        end
        return op;
    endfunction

    task automatic test_random_traffic();
        bit phase_modes [RANDOM_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        int per_phase;
        per_phase = RANDOM_ITEMS / RANDOM_PHASES;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            // pool mixes keys in and just past the array range, the all-ones key and random keys
            for (int i = 0; i < POOL_SIZE; i++) begin
                if (i < 8) begin
                    key_pool[i] = $urandom_range(0, NUM_SLOTS + 4);
                end else if (i == 8) begin
                    key_pool[i] = '1;
                end else begin
                    key_pool[i] = $urandom;
                end
            end
            write_table_mode(phase_modes[p]);
            for (int n = 0; n < per_phase; n++) begin
                // sender holds off mid-phase until the block has caught up
                if (n == per_phase / 2) wait_table_idle();
                send_item(random_table_op());
            end
        end
        wait_table_idle();
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        for (int i = 0; i < 5; i++) status_tally[i] = 0;
        load_table_for_mode(1'b0);
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_hash_directed();
        test_array_directed();
        test_table_full();
        test_random_traffic();

        wait_table_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d commands sent, %0d results checked, %0d table mode writes",
                 items_sent, results_checked, mode_writes);
        $display("status mix: ok %0d, not found %0d, exists %0d, full %0d, refused %0d",
                 status_tally[kvmt_pkg::ST_OK], status_tally[kvmt_pkg::ST_NOT_FOUND],
                 status_tally[kvmt_pkg::ST_EXISTS], status_tally[kvmt_pkg::ST_FULL],
                 status_tally[kvmt_pkg::ST_INVALID]);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     expected_results.size());
            $display("Verification failed");
        end
        $finish;
    end

endmodule
